// ----- hw/rtl/bhq_pkg.sv -----
package bhq_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // one result beat from the sequencer
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  min_value;
        logic [COUNT_W-1:0]         count;
        status_t                    status;
    } res_t;

endpackage

// ----- hw/rtl/binary_min_heap_queue.sv -----
// channel   ports                              handshake
// command   start, busy, command, value, index taken when start high and busy low
// result    done, min_value, count, status     one beat per command, done for one cycle
//
// done is registered from the sequencer's finishing step, busy covering the steps before it:
// an error or removal of the last slot answers straight from idle; an insert reads and
// compares each parent on its way up until it stops or reaches the root; a removal reads
// the last entry and the parent of the freed slot, then sifts up or down level by level;
// the worst case is set by one registered heap read and one compare step per level.
// reset empties the heap by clearing the entry count; the memory is not swept.
// the result beat lands in the cycle after the last memory write; done cannot be held off.
module binary_min_heap_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [bhq_pkg::VALUE_W-1:0] value,
    input  logic [bhq_pkg::INDEX_W-1:0]        index,
    output logic                               done,
    output logic signed [bhq_pkg::VALUE_W-1:0] min_value,
    output logic [bhq_pkg::COUNT_W-1:0]        count,
    output logic [bhq_pkg::STATUS_W-1:0]       status
);

    import bhq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [VALUE_W-1:0]        wdata;
    logic [ADDR_W-1:0]         raddr_a;
    logic [ADDR_W-1:0]         raddr_b;
    logic [VALUE_W-1:0]        rdata_a;
    logic [VALUE_W-1:0]        rdata_b;
    res_t                      res;

    logic                      done_reg;
    logic signed [VALUE_W-1:0] min_value_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [STATUS_W-1:0]       status_reg;

    // heap storage
    bhq_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // sift sequencer
    bhq_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .value   (value),
        .index   (index),
        .busy    (busy),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .res     (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            min_value_reg <= res.min_value;
            count_reg     <= res.count;
            status_reg    <= res.status;
        end
    end

    assign done      = done_reg;
    assign min_value = min_value_reg;
    assign count     = count_reg;
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    // a result beat only appears once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    // an accepted command either starts work or answers at once
    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command left no trace");

    // an empty heap reports a zero minimum
    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (count == '0)) |-> (min_value == '0))
        else $error("empty heap with non-zero minimum");
`endif

endmodule

// ----- hw/rtl/bhq_ram.sv -----
module bhq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/bhq_ctrl.sv -----
module bhq_ctrl #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              command,
    input  logic signed [bhq_pkg::VALUE_W-1:0] value,
    input  logic [bhq_pkg::INDEX_W-1:0]       index,
    output logic                              busy,
    output logic                              we,
    output logic [ADDR_W-1:0]                 waddr,
    output logic [bhq_pkg::VALUE_W-1:0]       wdata,
    output logic [ADDR_W-1:0]                 raddr_a,
    output logic [ADDR_W-1:0]                 raddr_b,
    input  logic [bhq_pkg::VALUE_W-1:0]       rdata_a,
    input  logic [bhq_pkg::VALUE_W-1:0]       rdata_b,
    output bhq_pkg::res_t                     res
);

    import bhq_pkg::*;

    localparam int XW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int ZW = ADDR_W + 2;
    localparam int YW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_UP_RD,
        S_UP_EV,
        S_DN_RD,
        S_DN_EV
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic [VALUE_W-1:0]         root_reg, root_next;

    logic [XW-1:0]              idx_x;
    logic [XW-1:0]              cnt_x;
    logic [CNT_W-1:0]           cnt_m1;
    logic [ADDR_W-1:0]          idx_a;
    logic [ADDR_W-1:0]          idx_par;
    logic [ADDR_W-1:0]          pos_par;
    logic [ZW-1:0]              left_z;
    logic [ZW-1:0]              right_z;
    logic                       left_ok;
    logic                       right_ok;
    logic signed [VALUE_W-1:0]  rd_a_s;
    logic signed [VALUE_W-1:0]  rd_b_s;
    logic signed [VALUE_W-1:0]  best_val;
    logic                       take_l;
    logic                       take_r;
    logic                       fin;
    status_t                    st;
    logic [YW-1:0]              cnt_y;

    // index and tree arithmetic
    assign idx_x    = XW'(index);
    assign cnt_x    = XW'(cnt_reg);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign idx_a    = idx_x[ADDR_W-1:0];
    assign idx_par  = ADDR_W'((idx_a - ADDR_W'(1)) >> 1);
    assign pos_par  = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign left_z   = {1'b0, pos_reg, 1'b1};
    assign right_z  = left_z + ZW'(1);
    assign left_ok  = left_z < ZW'(cnt_reg);
    assign right_ok = right_z < ZW'(cnt_reg);
    assign rd_a_s   = $signed(rdata_a);
    assign rd_b_s   = $signed(rdata_b);

    // pick the smallest of key and both children
    always_comb
    begin
        best_val = key_reg;
        take_l   = 1'b0;
        take_r   = 1'b0;
        if (rd_a_s < key_reg)
        begin
            best_val = rd_a_s;
            take_l   = 1'b1;
        end
        if (right_ok && (rd_b_s < best_val))
        begin
            take_r = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = key_reg;
        raddr_a    = '0;
        raddr_b    = '0;
        fin        = 1'b0;
        st         = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_INSERT)
                    begin
                        if (cnt_reg >= CNT_W'(DEPTH))
                        begin
                            fin = 1'b1;
                            st  = ST_FULL;
                        end
                        else
                        begin
                            key_next   = value;
                            pos_next   = cnt_reg[ADDR_W-1:0];
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if ((cnt_reg == '0) || (idx_x >= cnt_x))
                        begin
                            fin = 1'b1;
                            st  = ST_BAD;
                        end
                        else
                        begin
                            cnt_next = cnt_m1;
                            pos_next = idx_a;
                            raddr_a  = cnt_m1[ADDR_W-1:0];
                            raddr_b  = idx_par;
                            if (idx_x == XW'(cnt_m1))
                            begin
                                // last slot removed, nothing moves
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LAST;
                            end
                        end
                    end
                end
            end

            S_LAST:
            begin
                // last entry becomes the key; its first step decides the direction
                key_next = rd_a_s;
                if ((pos_reg != '0) && (rd_a_s < rd_b_s))
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = rdata_b;
                    pos_next   = pos_par;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we  = 1'b1;
                    fin = 1'b1;
                end
                else
                begin
                    raddr_a    = pos_par;
                    state_next = S_UP_EV;
                end
            end

            S_UP_EV:
            begin
                we = 1'b1;
                if (key_reg < rd_a_s)
                begin
                    wdata      = rdata_a;
                    pos_next   = pos_par;
                    state_next = S_UP_RD;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            S_DN_RD:
            begin
                if (!left_ok)
                begin
                    we  = 1'b1;
                    fin = 1'b1;
                end
                else
                begin
                    raddr_a    = left_z[ADDR_W-1:0];
                    raddr_b    = right_z[ADDR_W-1:0];
                    state_next = S_DN_EV;
                end
            end

            S_DN_EV:
            begin
                we = 1'b1;
                if (take_r)
                begin
                    wdata      = rdata_b;
                    pos_next   = right_z[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (take_l)
                begin
                    wdata      = rdata_a;
                    pos_next   = left_z[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    // root mirror so the minimum needs no memory read
    assign root_next = (we && (waddr == '0)) ? wdata : root_reg;
    assign cnt_y     = YW'(cnt_next);

    // result beat
    always_comb
    begin
        res.valid     = fin;
        res.min_value = (cnt_next == '0) ? '0 : $signed(root_next);
        res.count     = cnt_y[COUNT_W-1:0];
        res.status    = st;
    end

    assign busy = (state_reg != S_IDLE);

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        root_reg <= root_next;
    end

endmodule
